>>> rtl/mlwq_pkg.sv
// package with shared types and constants for the mutex wait queue
package mlwq_pkg;

  localparam int unsigned IdW = 8;

  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  typedef logic [IdW-1:0] thread_id_t;

  typedef struct packed {
    logic       valid;
    thread_id_t id;
  } slot_t;

  typedef struct packed {
    logic       remove;
    logic       append;
    thread_id_t id;
  } cell_ctrl_t;

endpackage

>>> rtl/mlwq_req_if.sv
// request channel carrying lock and unlock requests
interface mlwq_req_if;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  mlwq_pkg::thread_id_t  thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

>>> rtl/mlwq_rsp_if.sv
// response channel carrying grant, queue and wake-up results
interface mlwq_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic                  queued;
  logic                  queue_overflow;
  logic                  wake_valid;
  mlwq_pkg::thread_id_t  wake_thread;

  modport source (output valid, output granted, output queued, output queue_overflow,
                  output wake_valid, output wake_thread, input ready);
  modport sink   (input valid, input granted, input queued, input queue_overflow,
                  input wake_valid, input wake_thread, output ready);
endinterface

>>> rtl/mlwq_cell.sv
// one wait queue slot: removal shifts the neighbor in, append fills the first empty slot
module mlwq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  mlwq_pkg::cell_ctrl_t ctrl,
  input  logic                 prev_valid,
  input  mlwq_pkg::slot_t      next_slot,
  input  logic                 hit_in,
  output logic                 hit_out,
  output mlwq_pkg::slot_t      slot
);

  logic match;

  assign match   = slot.valid && (slot.id == ctrl.id);
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctrl.remove && hit_out) begin
      slot <= next_slot;
    end else if (ctrl.append && !slot.valid && prev_valid) begin
      slot.valid <= 1'b1;
      slot.id    <= ctrl.id;
    end
  end

endmodule

>>> rtl/mlwq_queue.sv
// compacted fifo of waiting thread ids built as a row of slot cells
module mlwq_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlwq_pkg::cell_ctrl_t ctrl,
  output mlwq_pkg::slot_t      head,
  output logic                 tail_valid,
  output logic                 hit_any
);

  mlwq_pkg::slot_t slots [QUEUE_DEPTH];
  mlwq_pkg::slot_t nexts [QUEUE_DEPTH];
  logic            prevs [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] hits;

  assign hits[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nexts[i] = '0;
    end else begin : g_mid
      assign nexts[i] = slots[i+1];
    end
    if (i == 0) begin : g_first
      assign prevs[i] = 1'b1;
    end else begin : g_rest
      assign prevs[i] = slots[i-1].valid;
    end

    mlwq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prevs[i]),
      .next_slot  (nexts[i]),
      .hit_in     (hits[i]),
      .hit_out    (hits[i+1]),
      .slot       (slots[i])
    );
  end

  assign head       = slots[0];
  assign tail_valid = slots[QUEUE_DEPTH-1].valid;
  assign hit_any    = hits[QUEUE_DEPTH];

endmodule

>>> rtl/mutex_lock_with_wait_queue.sv
// top level of the hardware mutex with a compacted wait queue
// the response is registered when the request is accepted
// a new request is not taken until the append state has passed; removal happens in the accept cycle
//   and the append into the slot row in the following cycle
// reset: mutex free, all queue slots empty, no pending response
module mutex_lock_with_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  mlwq_req_if.sink     req,
  mlwq_rsp_if.source   rsp
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_APPEND = 1'b1;

  logic                 state;
  logic                 state_next;
  logic                 held;
  logic                 do_append;
  mlwq_pkg::thread_id_t append_id;
  logic                 accept;
  logic                 is_lock;
  logic                 full_after;
  mlwq_pkg::cell_ctrl_t ctrl;
  mlwq_pkg::slot_t      head;
  logic                 tail_valid;
  logic                 hit_any;

  assign req.ready  = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign is_lock    = (req.kind == mlwq_pkg::KIND_LOCK);
  assign full_after = tail_valid && !hit_any;

  always_comb begin
    ctrl.remove = 1'b0;
    ctrl.append = 1'b0;
    ctrl.id     = req.thread_id;
    if (state == ST_APPEND) begin
      ctrl.append = do_append;
      ctrl.id     = append_id;
    end else begin
      ctrl.remove = accept && is_lock;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:   state_next = accept ? ST_APPEND : ST_IDLE;
      ST_APPEND: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  mlwq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head       (head),
    .tail_valid (tail_valid),
    .hit_any    (hit_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= 1'b0;
      do_append <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rsp.valid <= 1'b1;
        held      <= is_lock;
        do_append <= is_lock && held && !full_after;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      append_id          <= req.thread_id;
      rsp.granted        <= is_lock && !held;
      rsp.queued         <= is_lock && held && !full_after;
      rsp.queue_overflow <= is_lock && held && full_after;
      rsp.wake_valid     <= !is_lock && head.valid;
      rsp.wake_thread    <= (!is_lock && head.valid) ? head.id : '0;
    end
  end

endmodule

>>> sim/mlwq_checker.sv
// checker that predicts the mutex responses and compares them with the block
module mlwq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  mlwq_req_if         req,
  mlwq_rsp_if         rsp,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned requests,
  output int unsigned grants,
  output int unsigned queued_cnt,
  output int unsigned overflows,
  output int unsigned wakes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 granted;
    logic                 queued;
    logic                 queue_overflow;
    logic                 wake_valid;
    mlwq_pkg::thread_id_t wake_thread;
  } mutex_rsp_t;

  logic            mutex_held;
  mlwq_pkg::slot_t waiters [QUEUE_DEPTH];
  mutex_rsp_t      expected_rsps [$];

  function automatic mutex_rsp_t apply_request(logic kind, mlwq_pkg::thread_id_t id);
    mutex_rsp_t  r;
    int unsigned hit;
    logic        appended;
    r = '0;
    if (kind == mlwq_pkg::KIND_LOCK) begin
      hit = QUEUE_DEPTH;
      for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
        if (hit == QUEUE_DEPTH && waiters[i].valid && waiters[i].id == id) begin
          hit = i;
        end
      end
      if (hit < QUEUE_DEPTH) begin
        for (int unsigned i = hit; i + 1 < QUEUE_DEPTH; i++) begin
          waiters[i] = waiters[i+1];
        end
        waiters[QUEUE_DEPTH-1] = '0;
      end
      if (!mutex_held) begin
        mutex_held = 1'b1;
        r.granted = 1'b1;
      end else begin
        appended = 1'b0;
        for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
          if (!appended && !waiters[i].valid) begin
            waiters[i].valid = 1'b1;
            waiters[i].id = id;
            appended = 1'b1;
          end
        end
        r.queued = appended;
        r.queue_overflow = !appended;
      end
    end else begin
      if (waiters[0].valid) begin
        r.wake_valid = 1'b1;
        r.wake_thread = waiters[0].id;
      end
      mutex_held = 1'b0;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mutex_rsp_t got;
    mutex_rsp_t want;
    if (rst) begin
      mutex_held = 1'b0;
      for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
        waiters[i] = '0;
      end
      expected_rsps.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.granted, rsp.queued, rsp.queue_overflow, rsp.wake_valid, rsp.wake_thread};
        if (expected_rsps.size() == 0) begin
          failures++;
          $display("%0t: response with none pending, expected nothing, actual %p", $time, got);
        end else begin
          want = expected_rsps.pop_front();
          compare_field("granted", 8'(want.granted), 8'(got.granted));
          compare_field("queued", 8'(want.queued), 8'(got.queued));
          compare_field("queue_overflow", 8'(want.queue_overflow), 8'(got.queue_overflow));
          compare_field("wake_valid", 8'(want.wake_valid), 8'(got.wake_valid));
          compare_field("wake_thread", want.wake_thread, got.wake_thread);
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(req.kind, req.thread_id);
        expected_rsps.push_back(want);
        requests++;
        if (want.granted) grants++;
        if (want.queued) queued_cnt++;
        if (want.queue_overflow) overflows++;
        if (want.wake_valid) wakes++;
      end
    end
    outstanding = expected_rsps.size();
  end

endmodule

>>> sim/testbench.sv
// testbench top: clock, reset, lock and unlock traffic, response drain and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH      = 16;
  localparam int unsigned RANDOM_REQUESTS  = 2000;
  localparam int unsigned PHASE_LEN        = 100;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT_RESPONSE = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sender_calm = 1'b0;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned requests;
  int unsigned grants;
  int unsigned queued_cnt;
  int unsigned overflows;
  int unsigned wakes;

  mlwq_req_if req_ch ();
  mlwq_rsp_if rsp_ch ();

  always #10 clk = ~clk;

  mutex_lock_with_wait_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mlwq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .failures    (failures),
    .outstanding (outstanding),
    .requests    (requests),
    .grants      (grants),
    .queued_cnt  (queued_cnt),
    .overflows   (overflows),
    .wakes       (wakes)
  );

  task automatic send_request(logic kind, mlwq_pkg::thread_id_t id);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.thread_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    int unsigned          pool;
    int unsigned          lock_pct;
    mlwq_pkg::thread_id_t base;
    logic                 kind;
    mlwq_pkg::thread_id_t id;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= mlwq_pkg::KIND_LOCK;
    req_ch.thread_id <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // free mutex, empty queue, holder relocking, unlock while free
    send_request(mlwq_pkg::KIND_UNLOCK, 8'h00);
    send_request(mlwq_pkg::KIND_LOCK, 8'h00);
    send_request(mlwq_pkg::KIND_LOCK, 8'hFF);
    send_request(mlwq_pkg::KIND_LOCK, 8'h00);
    send_request(mlwq_pkg::KIND_UNLOCK, 8'hFF);
    send_request(mlwq_pkg::KIND_UNLOCK, 8'h5A);
    send_request(mlwq_pkg::KIND_LOCK, 8'h00);
    send_request(mlwq_pkg::KIND_LOCK, 8'hFF);
    // fill the queue, then overflow and a requeue from the middle
    for (int unsigned k = 0; k < QUEUE_DEPTH - 1; k++) begin
      send_request(mlwq_pkg::KIND_LOCK, mlwq_pkg::thread_id_t'(8'h10 + k));
    end
    send_request(mlwq_pkg::KIND_LOCK, 8'h7E);
    send_request(mlwq_pkg::KIND_LOCK, 8'h13);

    pool = 16;
    lock_pct = 50;
    base = '0;
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 3))
          0: pool = 4;
          1: pool = 16;
          2: pool = 24;
          default: pool = 256;
        endcase
        case ($urandom_range(0, 2))
          0: lock_pct = 30;
          1: lock_pct = 55;
          default: lock_pct = 80;
        endcase
        base = mlwq_pkg::thread_id_t'($urandom_range(0, 255));
        sender_calm <= ($urandom_range(0, 3) == 0);
      end
      kind = ($urandom_range(0, 99) < lock_pct) ? mlwq_pkg::KIND_LOCK : mlwq_pkg::KIND_UNLOCK;
      id = mlwq_pkg::thread_id_t'(base + $urandom_range(0, pool - 1));
      send_request(kind, id);
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests: %0d grants, %0d queued, %0d overflows, %0d wake-ups",
             requests, grants, queued_cnt, overflows, wakes);
    if (outstanding != 0) begin
      $display("%0d responses never arrived", outstanding);
    end
    if (failures == 0 && outstanding == 0) begin
      $display("PASS mutex_lock_with_wait_queue");
    end else begin
      $display("FAIL mutex_lock_with_wait_queue");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    logic        calm;
    taken = 0;
    calm = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken == HOLD_AT_RESPONSE) begin
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken++;
      if (taken % 150 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d responses pending", outstanding);
    $display("FAIL mutex_lock_with_wait_queue");
    $finish;
  end

endmodule
